// ----- rtl/vfv_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfv_pkg
// Shared types, constants and register map for the voxel face visibility core.
// ----------------------------------------------------------------------------
package vfv_pkg;

    // Default grid dimensions
    localparam int GRID_X_DEF = 32;
    localparam int GRID_Z_DEF = 32;
    localparam int GRID_H_DEF = 32;

    // Configuration register map
    localparam int          CFG_AW        = 4;
    localparam logic [1:0]  REG_MESH_MODE = 2'd0;
    localparam logic [1:0]  REG_AIR_CODE  = 2'd1;
    localparam logic [1:0]  REG_WATER_CODE = 2'd2;

    localparam logic [2:0]  AIR_CODE_RST   = 3'd0;
    localparam logic [2:0]  WATER_CODE_RST = 3'd1;

    // Item commands
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Read sequence: center voxel, then the six neighbors in face order
    localparam logic [2:0] STEP_CENTER = 3'd0;
    localparam logic [2:0] STEP_LEFT   = 3'd1;
    localparam logic [2:0] STEP_RIGHT  = 3'd2;
    localparam logic [2:0] STEP_BACK   = 3'd3;
    localparam logic [2:0] STEP_FRONT  = 3'd4;
    localparam logic [2:0] STEP_BOTTOM = 3'd5;
    localparam logic [2:0] STEP_TOP    = 3'd6;

    typedef struct packed {
        logic       cmd;
        logic [7:0] pos_x;
        logic [7:0] pos_z;
        logic [5:0] pos_y;
        logic [2:0] block_type;
    } vfv_in_t;

    typedef struct packed {
        logic [5:0] face_mask;
        logic [2:0] out_type;
        logic [7:0] out_x;
        logic [7:0] out_z;
        logic [5:0] out_y;
    } vfv_out_t;

    typedef struct packed {
        logic       mesh_mode;
        logic [2:0] air_code;
        logic [2:0] water_code;
    } vfv_cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADDR,
        ST_WRITE,
        ST_READ,
        ST_DRAIN,
        ST_DONE
    } vfv_state_t;

    typedef struct packed {
        logic load;
        logic calc_addr;
        logic mem_write;
        logic rd_issue;
        logic out_load;
    } vfv_cmd_t;

    typedef struct packed {
        logic is_write;
        logic in_grid;
        logic last_step;
        logic out_free;
    } vfv_status_t;

endpackage

// ----- rtl/vfv_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfv_regs
// APB configuration registers: mesh mode, air code and water code.
// ----------------------------------------------------------------------------
module vfv_regs
    import vfv_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output vfv_cfg_t          cfg
);

    vfv_cfg_t   cfg_reg;
    logic [1:0] reg_idx;
    logic       wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel & penable & pwrite & pready;
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mesh_mode  <= 1'b0;
            cfg_reg.air_code   <= AIR_CODE_RST;
            cfg_reg.water_code <= WATER_CODE_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_MESH_MODE:  cfg_reg.mesh_mode  <= pwdata[0];
                REG_AIR_CODE:   cfg_reg.air_code   <= pwdata[2:0];
                REG_WATER_CODE: cfg_reg.water_code <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_MESH_MODE:  prdata = {31'd0, cfg_reg.mesh_mode};
            REG_AIR_CODE:   prdata = {29'd0, cfg_reg.air_code};
            REG_WATER_CODE: prdata = {29'd0, cfg_reg.water_code};
            default:        prdata = 32'd0;
        endcase
    end

endmodule

// ----- rtl/vfv_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfv_ctrl
// Sequencer: accepts an item, then steps the datapath through the write or
// the seven voxel reads of an item inside the grid and hands each query result to the output stage.
// ----------------------------------------------------------------------------
module vfv_ctrl
    import vfv_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  vfv_status_t status,
    output vfv_cmd_t    cmd
);

    vfv_state_t state_reg;
    vfv_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_ADDR;
            end
            ST_ADDR: begin
                priority if (status.is_write && status.in_grid) state_next = ST_WRITE;
                else if (status.is_write)                       state_next = ST_IDLE;
                else if (status.in_grid)                        state_next = ST_READ;
                else                                            state_next = ST_DONE;
            end
            ST_WRITE: begin
                state_next = ST_IDLE;
            end
            ST_READ: begin
                if (status.last_step) state_next = ST_DRAIN;
            end
            ST_DRAIN: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (status.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_ADDR:  cmd.calc_addr = 1'b1;
            ST_WRITE: cmd.mem_write = 1'b1;
            ST_READ:  cmd.rd_issue  = 1'b1;
            ST_DRAIN: ;
            ST_DONE:  cmd.out_load  = status.out_free;
            default: ;
        endcase
    end

endmodule

// ----- rtl/vfv_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfv_datapath
// Voxel store, address generation, face evaluation and output register.
// ----------------------------------------------------------------------------
module vfv_datapath
    import vfv_pkg::*;
#(
    parameter int GRID_X = GRID_X_DEF,
    parameter int GRID_Z = GRID_Z_DEF,
    parameter int GRID_H = GRID_H_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  vfv_in_t     s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output vfv_out_t    m_data,
    input  vfv_cfg_t    cfg,
    input  vfv_cmd_t    cmd,
    output vfv_status_t status
);

    localparam int DEPTH = GRID_X * GRID_Z * GRID_H;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [AW-1:0] X_STRIDE = AW'(GRID_Z * GRID_H);
    localparam logic [AW-1:0] Z_STRIDE = AW'(GRID_H);
    localparam logic [AW-1:0] Y_STRIDE = AW'(1);

    localparam logic [8:0] X_SIZE = 9'(GRID_X);
    localparam logic [8:0] Z_SIZE = 9'(GRID_Z);
    localparam logic [6:0] Y_SIZE = 7'(GRID_H);
    localparam logic [7:0] X_LAST = 8'(GRID_X - 1);
    localparam logic [7:0] Z_LAST = 8'(GRID_Z - 1);
    localparam logic [5:0] Y_LAST = 6'(GRID_H - 1);

    logic [2:0]    mem [DEPTH];

    vfv_in_t       item_reg;
    logic [AW-1:0] center_addr_reg;
    logic [2:0]    step_reg;
    logic          rd_pending_reg;
    logic [2:0]    rd_step_reg;
    logic [2:0]    rd_data_reg;
    logic [2:0]    type_reg;
    logic [5:0]    mask_reg;
    logic          m_valid_reg;
    vfv_out_t      m_data_reg;

    logic [5:0]    border;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] center_addr;
    logic          in_grid;
    logic          nb_open;
    logic          qualifies;
    logic [2:0]    face_idx;

    assign in_grid = ({1'b0, item_reg.pos_x} < X_SIZE) &&
                     ({1'b0, item_reg.pos_z} < Z_SIZE) &&
                     ({1'b0, item_reg.pos_y} < Y_SIZE);

    assign border[0] = (item_reg.pos_x == 8'd0);
    assign border[1] = (item_reg.pos_x == X_LAST);
    assign border[2] = (item_reg.pos_z == 8'd0);
    assign border[3] = (item_reg.pos_z == Z_LAST);
    assign border[4] = (item_reg.pos_y == 6'd0);
    assign border[5] = (item_reg.pos_y == Y_LAST);

    assign center_addr = AW'(AW'(item_reg.pos_x) * X_STRIDE)
                       + AW'(AW'(item_reg.pos_z) * Z_STRIDE)
                       + AW'(item_reg.pos_y);

    // A border face needs no neighbor; read the center again instead
    always_comb begin
        unique case (step_reg)
            STEP_LEFT:   rd_addr = border[0] ? center_addr_reg : center_addr_reg - X_STRIDE;
            STEP_RIGHT:  rd_addr = border[1] ? center_addr_reg : center_addr_reg + X_STRIDE;
            STEP_BACK:   rd_addr = border[2] ? center_addr_reg : center_addr_reg - Z_STRIDE;
            STEP_FRONT:  rd_addr = border[3] ? center_addr_reg : center_addr_reg + Z_STRIDE;
            STEP_BOTTOM: rd_addr = border[4] ? center_addr_reg : center_addr_reg - Y_STRIDE;
            STEP_TOP:    rd_addr = border[5] ? center_addr_reg : center_addr_reg + Y_STRIDE;
            default:     rd_addr = center_addr_reg;
        endcase
    end

    assign nb_open = cfg.mesh_mode ? (rd_data_reg == cfg.air_code)
                                   : ((rd_data_reg == cfg.air_code) ||
                                      (rd_data_reg == cfg.water_code));
    assign qualifies = cfg.mesh_mode ? (type_reg == cfg.water_code)
                                     : ((type_reg != cfg.air_code) &&
                                        (type_reg != cfg.water_code));
    assign face_idx = rd_step_reg - 3'd1;

    // Single-port voxel store
    always_ff @(posedge aclk) begin
        if (cmd.mem_write) begin
            mem[center_addr_reg] <= item_reg.block_type;
        end
        if (cmd.rd_issue) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg <= s_data;
        end
        if (cmd.calc_addr) begin
            center_addr_reg <= center_addr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg       <= STEP_CENTER;
            rd_pending_reg <= 1'b0;
            rd_step_reg    <= STEP_CENTER;
            type_reg       <= 3'd0;
            mask_reg       <= 6'd0;
        end else begin
            rd_pending_reg <= cmd.rd_issue;
            rd_step_reg    <= step_reg;
            if (cmd.load) begin
                step_reg <= STEP_CENTER;
                type_reg <= 3'd0;
                mask_reg <= 6'd0;
            end else if (cmd.rd_issue) begin
                step_reg <= step_reg + 3'd1;
            end
            // Evaluate the word read in the previous cycle
            if (rd_pending_reg) begin
                if (rd_step_reg == STEP_CENTER) begin
                    type_reg <= rd_data_reg;
                end else begin
                    mask_reg[face_idx] <= border[face_idx] | nb_open;
                end
            end
        end
    end

    // Output register frees the sequencer while the result waits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_data_reg.face_mask <= qualifies ? mask_reg : 6'd0;
            m_data_reg.out_type  <= type_reg;
            m_data_reg.out_x     <= item_reg.pos_x;
            m_data_reg.out_z     <= item_reg.pos_z;
            m_data_reg.out_y     <= item_reg.pos_y;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign status.is_write  = (item_reg.cmd == CMD_WRITE);
    assign status.in_grid   = in_grid;
    assign status.last_step = (step_reg == STEP_TOP);
    assign status.out_free  = !m_valid_reg || m_ready;

endmodule

// ----- rtl/voxel_face_visibility_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_face_visibility_core
// Voxel grid of 3-bit block codes with a visible-face query.
// ----------------------------------------------------------------------------
// A write inside the grid passes through address calculation and the store
// write before the next item can be accepted, a write outside the grid
// through address calculation only; a query also waits for the previous
// result to be taken before its output is loaded. The query time is set by
// the single-port voxel store: after address calculation, the voxel and its
// six neighbors are read one per cycle, the last read is drained, the output
// register is loaded and the sequencer returns to idle to accept the
// next transfer. Each query gives one result transfer; writes give none.
// Store contents are undefined after reset, so every voxel must be written
// before it or a neighbor is queried. Registers: mesh_mode at 0x0, air_code
// at 0x4, water_code at 0x8.
// ----------------------------------------------------------------------------
module voxel_face_visibility_core
    import vfv_pkg::*;
#(
    parameter int GRID_X = GRID_X_DEF,
    parameter int GRID_Z = GRID_Z_DEF,
    parameter int GRID_H = GRID_H_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  vfv_in_t           s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output vfv_out_t          m_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    vfv_cfg_t    cfg;
    vfv_cmd_t    cmd;
    vfv_status_t status;

    vfv_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    vfv_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    vfv_datapath #(
        .GRID_X (GRID_X),
        .GRID_Z (GRID_Z),
        .GRID_H (GRID_H)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .cfg     (cfg),
        .cmd     (cmd),
        .status  (status)
    );

endmodule
